>>> sv/touch_point_event_tracker_defines.svh
// Assertion macros shared by the tracker RTL.
`ifndef TOUCH_POINT_EVENT_TRACKER_DEFINES_SVH
`define TOUCH_POINT_EVENT_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TPET_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TPET_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tpet_pkg.sv
`default_nettype none

package tpet_pkg;

  localparam int TPET_MAX_POINTS = 5;
  localparam int TPET_ID_SLOTS   = 16;

  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 88;
  localparam int M_USER_W = 4;
  localparam int COORD_W  = 16;
  localparam int ENTRY_W  = 3 * COORD_W;

  localparam logic OP_STATUS = 1'b0;
  localparam logic OP_POINT  = 1'b1;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DOWN = 2'd1;
  localparam logic [1:0] EV_MOVE = 2'd2;
  localparam logic [1:0] EV_UP   = 2'd3;

  localparam logic [1:0] FS_OK        = 2'd0;
  localparam logic [1:0] FS_NOT_READY = 2'd1;
  localparam logic [1:0] FS_BAD_COUNT = 2'd2;

  localparam logic [7:0]         READY_MASK = 8'h80;
  localparam logic [7:0]         COUNT_MASK = 8'h0F;
  localparam logic [COORD_W-1:0] NONE_VAL   = 16'hFFFF;

  typedef struct packed {
    logic [1:0]                touch_event;
    logic [3:0]                track_num;
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_size;
    logic [31:0]               out_time;
    logic [1:0]                frame_status;
  } result_t;

  typedef struct packed {
    logic    produce;
    logic    finish;
    result_t res;
  } tpet_req_t;

  typedef struct packed {
    logic ok;
    logic pend_valid;
  } tpet_sts_t;

  // Fold a 4-bit id into the slot range (slots is at least 5).
  function automatic logic [3:0] fold_id(input logic [3:0] v, input int unsigned slots);
    logic [3:0] r;
    r = v;
    for (int k = 0; k < 3; k++) begin
      if (32'(r) >= slots) begin
        r = 4'(32'(r) - slots);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/tpet_ram.sv
`default_nettype none

module tpet_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/tpet_out_stage.sv
`default_nettype none

module tpet_out_stage import tpet_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tpet_req_t           req,
  output tpet_sts_t                sts,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,  // track_num, out_x, out_y, out_size, out_time
  output logic [M_USER_W-1:0]      m_tuser,  // touch_event, frame_status
  output logic                     m_tlast
);

  result_t pend;
  logic    pend_valid;
  result_t out_q;
  logic    out_free;
  logic    push;

  // The pending word is held back until it is known whether it is the last.
  assign out_free       = !m_tvalid || m_tready;
  assign sts.ok         = !pend_valid || out_free;
  assign sts.pend_valid = pend_valid;
  assign push           = sts.ok && pend_valid && (req.produce || req.finish);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (sts.ok && req.produce) begin
        pend_valid <= 1'b1;
      end else if (sts.ok && req.finish) begin
        pend_valid <= 1'b0;
      end
      if (push) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sts.ok && req.produce) begin
      pend <= req.res;
    end
    if (push) begin
      out_q   <= pend;
      m_tlast <= req.finish;
    end
  end

  assign m_tdata = {4'b0000, out_q.out_time, out_q.out_size, out_q.out_y, out_q.out_x,
                    out_q.track_num};
  assign m_tuser = {out_q.frame_status, out_q.touch_event};

endmodule

`default_nettype wire

>>> sv/touch_point_event_tracker.sv
// Words are taken only in S_IDLE, so no new word is taken before the last is done. A
// rejected status gives one flagged word; a point gives its DOWN/MOVE word from S_PT_EM;
// an empty frame, or the point closing a frame, walks the previous ids in S_REL_RD and
// S_REL_EM, reading the coordinate RAM and then using it, for UP words. Each word waits
// in the pending register until its last flag is known, then goes to the output register.
// Reset: synchronous, no clearing pass; a clear valid flop reads as -1.
`default_nettype none

`include "touch_point_event_tracker_defines.svh"

module touch_point_event_tracker import tpet_pkg::*; #(
  parameter int MAX_POINTS = TPET_MAX_POINTS,
  parameter int ID_SLOTS   = TPET_ID_SLOTS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // status_byte, point_id, pos_x, pos_y,
                                             // contact_size, time_stamp
  input  wire logic                s_tuser,  // opcode
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,  // track_num, out_x, out_y, out_size, out_time
  output logic [M_USER_W-1:0]      m_tuser,  // touch_event, frame_status
  output logic                     m_tlast   // last_result
);

  localparam int IdW  = (ID_SLOTS > 1) ? $clog2(ID_SLOTS) : 1;
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int IdxW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PT_EM  = 5'b00010,
    S_REL_RD = 5'b00100,
    S_REL_EM = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state, state_next;

  // Input word fields.
  logic [7:0]  in_status;
  logic [3:0]  in_pid;
  logic [14:0] in_x, in_y, in_size;
  logic [31:0] in_time;
  logic [3:0]  in_cnt;
  logic        in_ready;
  logic        st_bad;
  logic [IdW-1:0] in_fid;

  assign in_status = s_tdata[7:0];
  assign in_pid    = s_tdata[11:8];
  assign in_x      = s_tdata[26:12];
  assign in_y      = s_tdata[41:27];
  assign in_size   = s_tdata[56:42];
  assign in_time   = s_tdata[88:57];
  assign in_cnt    = 4'(in_status & COUNT_MASK);
  assign in_ready  = (in_status & READY_MASK) != 8'h00;
  assign st_bad    = (in_status == 8'h00) || !in_ready || (in_cnt > 4'(MAX_POINTS));
  assign in_fid    = IdW'(fold_id(in_pid, ID_SLOTS));

  // Tracking state outside the RAM.
  logic [ID_SLOTS-1:0] valid_bits;  // set: id is down and its RAM entry holds its coordinates
  logic [IdW-1:0]      prev_ids [MAX_POINTS];
  logic [IdW-1:0]      cur_ids  [MAX_POINTS];
  logic [CntW-1:0]     prev_count, expected, received;
  logic [CntW-1:0]     walk_i, walk_n;

  // Item held while its results are built.
  logic [IdW-1:0] fid_q;
  logic [14:0]    x_q, y_q, s_q;
  logic [31:0]    t_q;

  logic accept, is_point, pt_take;
  logic [IdW-1:0] rel_id;
  logic present;
  logic walk_end;

  // RAM port signals.
  logic               ram_we, ram_re;
  logic [IdW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  tpet_req_t req;
  tpet_sts_t sts;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_point = (s_tuser == OP_POINT);
  // A point counts only inside an open frame and up to the announced count.
  assign pt_take  = (expected != '0) && (received < expected);
  assign rel_id   = prev_ids[walk_i[IdxW-1:0]];
  assign walk_end = (walk_i >= prev_count);

  // Compare the previous id under the walk against every id of the new frame.
  always_comb begin
    present = 1'b0;
    for (int j = 0; j < MAX_POINTS; j++) begin
      if ((CntW'(j) < walk_n) && (cur_ids[j] == rel_id)) begin
        present = 1'b1;
      end
    end
  end

  assign ram_wdata = {1'b0, x_q, 1'b0, y_q, 1'b0, s_q};

  always_comb begin
    state_next = state;
    req        = '0;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    ram_raddr  = in_fid;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!is_point) begin
            if (st_bad) begin
              // Reject the frame with one flagged word.
              req.produce              = 1'b1;
              req.res.touch_event      = EV_NONE;
              req.res.track_num        = 4'd0;
              req.res.out_x            = NONE_VAL;
              req.res.out_y            = NONE_VAL;
              req.res.out_size         = NONE_VAL;
              req.res.out_time         = in_time;
              req.res.frame_status     = (in_status == 8'h00 || !in_ready) ?
                                         FS_NOT_READY : FS_BAD_COUNT;
              state_next = S_DONE;
            end else if (in_cnt == 4'd0) begin
              // Empty frame: release every previous id.
              state_next = S_REL_RD;
            end
          end else if (pt_take) begin
            // Take the point; its word is built next cycle.
            state_next = S_PT_EM;
          end
        end
      end
      S_PT_EM: begin
        if (sts.ok) begin
          req.produce          = 1'b1;
          req.res.touch_event  = valid_bits[fid_q] ? EV_MOVE : EV_DOWN;
          req.res.track_num    = 4'(fid_q);
          req.res.out_x        = {1'b0, x_q};
          req.res.out_y        = {1'b0, y_q};
          req.res.out_size     = {1'b0, s_q};
          req.res.out_time     = t_q;
          req.res.frame_status = FS_OK;
          ram_we               = 1'b1;
          state_next           = (received == expected) ? S_REL_RD : S_DONE;
        end
      end
      S_REL_RD: begin
        ram_raddr = rel_id;
        if (walk_end) begin
          state_next = S_DONE;
        end else if (!present) begin
          ram_re     = 1'b1;
          state_next = S_REL_EM;
        end
      end
      S_REL_EM: begin
        ram_raddr = rel_id;
        if (sts.ok) begin
          // A cleared valid bit means already up: report none with -1 coordinates.
          req.produce          = 1'b1;
          req.res.touch_event  = valid_bits[rel_id] ? EV_UP : EV_NONE;
          req.res.track_num    = 4'(rel_id);
          req.res.out_x        = valid_bits[rel_id] ? ram_rdata[47:32] : NONE_VAL;
          req.res.out_y        = valid_bits[rel_id] ? ram_rdata[31:16] : NONE_VAL;
          req.res.out_size     = valid_bits[rel_id] ? ram_rdata[15:0]  : NONE_VAL;
          req.res.out_time     = t_q;
          req.res.frame_status = FS_OK;
          state_next           = S_REL_RD;
        end
      end
      S_DONE: begin
        // Flush the held word with its last flag.
        if (sts.ok) begin
          req.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      valid_bits <= '0;
      prev_count <= '0;
      expected   <= '0;
      received   <= '0;
      walk_i     <= '0;
      walk_n     <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (!is_point) begin
              // Any status word abandons the frame in progress.
              expected <= '0;
              received <= '0;
              if (!st_bad) begin
                if (in_cnt == 4'd0) begin
                  walk_i <= '0;
                  walk_n <= '0;
                end else begin
                  expected <= CntW'(in_cnt);
                end
              end
            end else if (pt_take) begin
              received <= received + CntW'(1);
            end
          end
        end
        S_PT_EM: begin
          if (sts.ok) begin
            valid_bits[fid_q] <= 1'b1;
            if (received == expected) begin
              walk_i <= '0;
              walk_n <= expected;
            end
          end
        end
        S_REL_RD: begin
          if (walk_end) begin
            // Close the frame: the new ids become the previous frame.
            prev_count <= walk_n;
            expected   <= '0;
            received   <= '0;
          end else if (present) begin
            walk_i <= walk_i + CntW'(1);
          end
        end
        S_REL_EM: begin
          if (sts.ok) begin
            valid_bits[rel_id] <= 1'b0;
            walk_i             <= walk_i + CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Item payload and id lists.
  always_ff @(posedge clk) begin
    if (accept) begin
      fid_q <= in_fid;
      x_q   <= in_x;
      y_q   <= in_y;
      s_q   <= in_size;
      t_q   <= in_time;
      if (is_point && pt_take) begin
        cur_ids[received[IdxW-1:0]] <= in_fid;
      end
    end
    if (state == S_REL_RD && walk_end && walk_n != '0) begin
      prev_ids <= cur_ids;
    end
  end

  tpet_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ID_SLOTS)
  ) u_coord_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fid_q),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tpet_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  `TPET_ASSERT_IMP(a_idle_no_pend, clk, rst, state == S_IDLE, !sts.pend_valid, "word left pending in idle")
  `TPET_ASSERT_IMP(a_recv_bound, clk, rst, 1'b1, received <= expected, "received count above expected")
  `TPET_ASSERT_IMP(a_walk_bound, clk, rst, state == S_REL_EM, walk_i < prev_count, "release walk out of range")
  `TPET_ASSERT_NXT(a_point_down, clk, rst, state == S_PT_EM && sts.ok, valid_bits[$past(fid_q)], "point id not marked down")

endmodule

`default_nettype wire

>>> dv/touch_point_event_tracker_test.sv
`default_nettype none

module touch_point_event_tracker_test;
  import tpet_pkg::*;

  localparam int WORD_TARGET = 470;   // counted input words for the whole run
  localparam int STALL_LIMIT = 3000;  // cycles with no handshake on either side
  localparam int TAIL_CYCLES = 60;    // covers the longest frame-closing walk

  // One input word as the generator builds it, plus run control bits.
  typedef struct {
    logic        opcode;
    logic [7:0]  status_byte;
    logic [3:0]  point_id;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [14:0] contact_size;
    logic [31:0] time_stamp;
    int          phase;        // selects the idle mix on both sides
    bit          drain_first;  // hold this word until every due result is in
  } touch_word_t;

  typedef struct {
    result_t r;
    bit      last;
  } due_result_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata  = '0;
  logic                s_tuser  = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic                m_tlast;

  touch_point_event_tracker i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Tracker state as the block should hold it
  // ---------------------------------------------------------------------------
  bit          trk_down [TPET_ID_SLOTS];
  logic [15:0] trk_x    [TPET_ID_SLOTS];
  logic [15:0] trk_y    [TPET_ID_SLOTS];
  logic [15:0] trk_size [TPET_ID_SLOTS];
  logic [3:0]  held_ids [TPET_MAX_POINTS];  // ids of the last completed frame
  int          held_n   = 0;
  logic [3:0]  open_ids [TPET_MAX_POINTS];  // ids of the frame being collected
  int          open_want = 0;
  int          open_got  = 0;

  due_result_t due_q[$];
  touch_word_t pending[$];
  touch_word_t drive_w;

  int   mismatch_count = 0;
  int   stall_cycles   = 0;
  int   rcv_phase      = 0;
  logic word_taken     = 1'b0;

  int   gen_phase = 0;
  bit   gen_drain = 1'b0;
  int   gen_count = 0;

  task automatic note_mismatch(input string msg);
    $display("%0t: mismatch, %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void push_due(input logic [1:0] ev, input logic [3:0] id,
                                   input logic [15:0] x, input logic [15:0] y,
                                   input logic [15:0] sz, input logic [31:0] ts,
                                   input logic [1:0] fs);
    due_result_t d;
    d.r.touch_event  = ev;
    d.r.track_num    = id;
    d.r.out_x        = x;
    d.r.out_y        = y;
    d.r.out_size     = sz;
    d.r.out_time     = ts;
    d.r.frame_status = fs;
    d.last           = 1'b0;
    due_q.push_back(d);
  endfunction

  // Release one id: UP if it is still down, otherwise a plain report of the
  // stored coordinates (an id listed twice in a frame). Forget them after.
  function automatic void lift_track(input logic [3:0] id, input logic [31:0] ts);
    logic [1:0] ev;
    ev = trk_down[id] ? EV_UP : EV_NONE;
    trk_down[id] = 1'b0;
    push_due(ev, id, trk_x[id], trk_y[id], trk_size[id], ts, FS_OK);
    trk_x[id]    = NONE_VAL;
    trk_y[id]    = NONE_VAL;
    trk_size[id] = NONE_VAL;
  endfunction

  // Work out the results of one accepted input word.
  function automatic void track_word(input logic op, input logic [S_DATA_W-1:0] d);
    logic [7:0]  st;
    logic [3:0]  cnt;
    logic [3:0]  id;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] sz;
    logic [31:0] ts;
    bit          present;
    int          first_new;
    st        = d[7:0];
    id        = 4'(int'(d[11:8]) % TPET_ID_SLOTS);
    x         = {1'b0, d[26:12]};
    y         = {1'b0, d[41:27]};
    sz        = {1'b0, d[56:42]};
    ts        = d[88:57];
    first_new = due_q.size();
    if (op == OP_STATUS) begin
      cnt       = 4'(st & COUNT_MASK);
      open_want = 0;
      open_got  = 0;
      if ((st & READY_MASK) == 0 || cnt > TPET_MAX_POINTS) begin
        // rejected frame: one flagged word, tracking left alone
        push_due(EV_NONE, 4'd0, NONE_VAL, NONE_VAL, NONE_VAL, ts,
                 ((st & READY_MASK) == 0) ? FS_NOT_READY : FS_BAD_COUNT);
      end else if (cnt == 0) begin
        for (int i = 0; i < held_n; i++) lift_track(held_ids[i], ts);
        held_n = 0;
      end else begin
        open_want = cnt;
      end
    end else if (open_want != 0 && open_got < open_want) begin
      open_ids[open_got] = id;
      open_got++;
      push_due(trk_down[id] ? EV_MOVE : EV_DOWN, id, x, y, sz, ts, FS_OK);
      trk_down[id] = 1'b1;
      trk_x[id]    = x;
      trk_y[id]    = y;
      trk_size[id] = sz;
      if (open_got == open_want) begin
        // frame complete: release every previous id that did not come back
        for (int i = 0; i < held_n; i++) begin
          present = 1'b0;
          for (int j = 0; j < open_want; j++)
            if (open_ids[j] == held_ids[i]) present = 1'b1;
          if (!present) lift_track(held_ids[i], ts);
        end
        for (int j = 0; j < open_want; j++) held_ids[j] = open_ids[j];
        held_n    = open_want;
        open_want = 0;
        open_got  = 0;
      end
    end
    // stray point words fall through with nothing due
    if (due_q.size() > first_new) due_q[due_q.size() - 1].last = 1'b1;
  endfunction

  // Compare one output word against the oldest due result, field by field.
  task automatic check_result(input logic [M_DATA_W-1:0] d,
                              input logic [M_USER_W-1:0] u, input logic l);
    due_result_t e;
    if (due_q.size() == 0) begin
      note_mismatch($sformatf("word with nothing due: event %0d track %0d",
                              u[1:0], d[3:0]));
      return;
    end
    e = due_q.pop_front();
    if (u[1:0] != e.r.touch_event)
      note_mismatch($sformatf("touch_event %0d, want %0d", u[1:0], e.r.touch_event));
    if (d[3:0] != e.r.track_num)
      note_mismatch($sformatf("track_num %0d, want %0d", d[3:0], e.r.track_num));
    if (d[19:4] != e.r.out_x)
      note_mismatch($sformatf("out_x %0h, want %0h", d[19:4], e.r.out_x));
    if (d[35:20] != e.r.out_y)
      note_mismatch($sformatf("out_y %0h, want %0h", d[35:20], e.r.out_y));
    if (d[51:36] != e.r.out_size)
      note_mismatch($sformatf("out_size %0h, want %0h", d[51:36], e.r.out_size));
    if (d[83:52] != e.r.out_time)
      note_mismatch($sformatf("out_time %0h, want %0h", d[83:52], e.r.out_time));
    if (u[3:2] != e.r.frame_status)
      note_mismatch($sformatf("frame_status %0d, want %0d", u[3:2], e.r.frame_status));
    if (l != e.last)
      note_mismatch($sformatf("tlast %0b, want %0b", l, e.last));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  function automatic void queue_word(input logic op, input logic [7:0] st,
                                     input logic [3:0] id, input logic [14:0] x,
                                     input logic [14:0] y, input logic [14:0] sz,
                                     input logic [31:0] ts);
    touch_word_t w;
    w.opcode       = op;
    w.status_byte  = st;
    w.point_id     = id;
    w.pos_x        = x;
    w.pos_y        = y;
    w.contact_size = sz;
    w.time_stamp   = ts;
    w.phase        = gen_phase;
    w.drain_first  = gen_drain;
    gen_drain      = 1'b0;
    pending.push_back(w);
  endfunction

  // Point fields of a status word carry noise; the block must ignore them.
  function automatic void queue_status(input logic [7:0] st, input logic [31:0] ts);
    queue_word(OP_STATUS, st, 4'($urandom), 15'($urandom), 15'($urandom),
               15'($urandom), ts);
    gen_count++;
  endfunction

  function automatic void queue_point(input logic [3:0] id, input logic [14:0] x,
                                      input logic [14:0] y, input logic [14:0] sz,
                                      input logic [31:0] ts);
    queue_word(OP_POINT, 8'($urandom), id, x, y, sz, ts);
    gen_count++;
  endfunction

  function automatic logic [14:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 15'h0000;
      1:       return 15'h7FFF;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  // Favor a small id pool so that MOVE and UP come up often.
  function automatic logic [3:0] pick_id();
    if ($urandom_range(0, 3) != 0) return 4'($urandom_range(0, 7));
    return 4'($urandom_range(0, 15));
  endfunction

  // Percent of cycles a side holds off: receiver-heavy, then sender-heavy, then none.
  function automatic int idle_share(input int phase, input bit sender);
    case (phase)
      0:       return sender ? 33 : 77;
      1:       return sender ? 77 : 33;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present words at the falling edge, advance only after a handshake
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (pending.size() != 0 && !(pending[0].drain_first && due_q.size() != 0) &&
          $urandom_range(0, 99) >= idle_share(pending[0].phase, 1'b1)) begin
        drive_w   = pending.pop_front();
        s_tuser  <= drive_w.opcode;
        s_tdata  <= {7'd0, drive_w.time_stamp, drive_w.contact_size, drive_w.pos_y,
                     drive_w.pos_x, drive_w.point_id, drive_w.status_byte};
        s_tvalid  <= 1'b1;
        rcv_phase <= drive_w.phase;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure follows the phase of the latest word sent.
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(0, 99) >= idle_share(rcv_phase, 1'b0));
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every input handshake, check on every output handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) track_word(s_tuser, s_tdata);
      if (m_tvalid && m_tready) check_result(m_tdata, m_tuser, m_tlast);
    end
  end

  // Watchdog: end the run if no handshake happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("touch_point_event_tracker_test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int         kind;
    int         cnt;
    int         sent;
    int         new_phase;
    logic [3:0] id;
    logic [3:0] prev_id;
    logic [7:0] st;

    for (int i = 0; i < TPET_ID_SLOTS; i++) begin
      trk_down[i] = 1'b0;
      trk_x[i]    = NONE_VAL;
      trk_y[i]    = NONE_VAL;
      trk_size[i] = NONE_VAL;
    end
    for (int i = 0; i < TPET_MAX_POINTS; i++) begin
      held_ids[i] = 4'd0;
      open_ids[i] = 4'd0;
    end

    // Directed: rejected status words (empty, not ready, count too high)
    queue_status(8'h00, 32'h0000_0000);
    queue_status(8'h7F, 32'hFFFF_FFFF);
    queue_status(8'h86, $urandom());
    queue_status(8'hFF, $urandom());
    // empty frame with nothing down yet, then a point with no frame open
    queue_status(8'h80, $urandom());
    queue_word(OP_POINT, 8'h00, 4'd7, 15'h1111, 15'h2222, 15'h3333, $urandom());
    // full frame at the field extremes: all DOWN
    queue_status(8'h85, $urandom());
    queue_point(4'd0,  15'h0000, 15'h0000, 15'h0000, 32'h0000_0000);
    queue_point(4'd15, 15'h7FFF, 15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
    queue_point(4'd5,  15'h5555, 15'h2AAA, 15'h1234, 32'h5555_5555);
    queue_point(4'd10, 15'h2AAA, 15'h5555, 15'h7FFF, 32'hAAAA_AAAA);
    queue_point(4'd3,  pick_coord(), pick_coord(), pick_coord(), $urandom());
    // point beyond the announced count: ignored
    queue_word(OP_POINT, 8'h00, 4'd1, 15'h0001, 15'h0002, 15'h0003, $urandom());
    // upper status bits set; same id twice: two MOVEs, then UPs for the rest
    queue_status(8'hF2, $urandom());
    queue_point(4'd15, pick_coord(), pick_coord(), pick_coord(), $urandom());
    queue_point(4'd15, pick_coord(), pick_coord(), pick_coord(), $urandom());
    // abandoned frame, then a one-point frame: repeated id releases UP then none
    queue_status(8'h83, $urandom());
    queue_point(4'd9, pick_coord(), pick_coord(), pick_coord(), $urandom());
    queue_status(8'h81, $urandom());
    queue_point(4'd9, pick_coord(), pick_coord(), pick_coord(), $urandom());
    // zero count releases the previous frame, a second one has nothing left
    queue_status(8'h80, $urandom());
    queue_status(8'h80, $urandom());

    // Random part: mostly well-formed frames with random content
    while (gen_count < WORD_TARGET) begin
      new_phase = (gen_count * 3) / WORD_TARGET;
      if (new_phase > 2) new_phase = 2;
      if (new_phase != gen_phase) begin
        gen_phase = new_phase;
        gen_drain = 1'b1;  // pause the sender until the block has drained
      end
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        cnt = $urandom_range(0, TPET_MAX_POINTS);
        queue_status(8'h80 | 8'($urandom_range(0, 7) << 4) | 8'(cnt), $urandom());
        prev_id = pick_id();
        for (int k = 0; k < cnt; k++) begin
          id = ($urandom_range(0, 9) == 0) ? prev_id : pick_id();
          queue_point(id, pick_coord(), pick_coord(), pick_coord(), $urandom());
          prev_id = id;
        end
      end else if (kind < 78) begin
        // truncated frame: the next status word abandons it
        cnt  = $urandom_range(2, TPET_MAX_POINTS);
        sent = $urandom_range(1, cnt - 1);
        queue_status(8'h80 | 8'(cnt), $urandom());
        for (int k = 0; k < sent; k++)
          queue_point(pick_id(), pick_coord(), pick_coord(), pick_coord(), $urandom());
      end else if (kind < 86) begin
        // stray point words, not counted
        for (int k = 0; k < $urandom_range(1, 2); k++)
          queue_word(OP_POINT, 8'($urandom), pick_id(), pick_coord(), pick_coord(),
                     pick_coord(), $urandom());
      end else if (kind < 95) begin
        case ($urandom_range(0, 2))
          0:       st = 8'h00;
          1:       st = 8'($urandom_range(0, 127));
          default: st = 8'h80 | 8'($urandom_range(0, 7) << 4) | 8'($urandom_range(6, 15));
        endcase
        queue_status(st, $urandom());
      end else begin
        queue_word(1'($urandom_range(0, 1)), 8'($urandom), 4'($urandom), 15'($urandom),
                   15'($urandom), 15'($urandom), $urandom());
        gen_count++;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // drain: all words sent, all results in, then let the block settle
    while (pending.size() != 0 || s_tvalid) @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("touch_point_event_tracker_test passed");
    end else begin
      $display("touch_point_event_tracker_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
